@@ src/gadj_pkg.sv @@
// Shared types and constants for the graph adjacency store.
package gadj_pkg;

    localparam int unsigned MAX_VERTICES_DEF = 64;
    localparam int unsigned MAX_DEGREE_DEF   = 16;
    localparam int unsigned QUEUE_DEPTH      = 2;
    localparam int unsigned VTX_W            = 6;
    localparam int unsigned CNT_W            = 7;
    localparam logic [CNT_W-1:0] VCOUNT_RST  = 7'd64;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef struct packed {
        cmd_t             op;
        logic             range_err;
        logic [VTX_W-1:0] src;
        logic [VTX_W-1:0] dst;
    } item_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_LEN_SRC,
        S_LEN_DST,
        S_INS_STEP,
        S_INS_CMP,
        S_RD_LEN,
        S_RD_ADDR,
        S_RD_DATA,
        S_CLR,
        S_RESP
    } back_state_t;

endpackage

@@ src/graph_adjacency_sorted_store.sv @@
// An add shifts each larger entry of a list up through the neighbor memory before it
// places the new one; a read returns the list entry by entry; a clear resets one
// length entry per cycle. Commands run one at a time, with a two-word queue in front.
// After reset the length memory is swept with s_axis_tready low; configuration writes
// are taken.
module graph_adjacency_sorted_store #(
    parameter int unsigned MAX_VERTICES = gadj_pkg::MAX_VERTICES_DEF,
    parameter int unsigned MAX_DEGREE   = gadj_pkg::MAX_DEGREE_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [gadj_pkg::CNT_W-1:0] cfg_wdata,     // vertex_count
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [15:0]                s_axis_tdata,  // src_vertex[5:0], dst_vertex[11:6]
    input  logic [1:0]                 s_axis_tuser,  // cmd
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [7:0]                 m_axis_tdata,  // status[1:0], neighbor[7:2]
    output logic                       m_axis_tlast
);

    logic            q_push;
    logic            q_pop;
    logic            q_full;
    logic            q_empty;
    logic            init_done;
    gadj_pkg::item_t push_item;
    gadj_pkg::item_t head_item;

    gadj_front #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .q_full       (q_full),
        .init_done    (init_done),
        .q_push       (q_push),
        .q_item       (push_item)
    );

    gadj_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_item(push_item),
        .pop      (q_pop),
        .head_item(head_item),
        .full     (q_full),
        .empty    (q_empty)
    );

    gadj_back #(
        .MAX_VERTICES(MAX_VERTICES),
        .MAX_DEGREE  (MAX_DEGREE)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_item       (head_item),
        .q_pop        (q_pop),
        .init_done    (init_done),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

endmodule

@@ src/gadj_front.sv @@
// Front end: takes command words, checks vertex range and classifies them.
module gadj_front #(
    parameter int unsigned MAX_VERTICES = gadj_pkg::MAX_VERTICES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [gadj_pkg::CNT_W-1:0] cfg_wdata,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [15:0]                s_axis_tdata,
    input  logic [1:0]                 s_axis_tuser,
    input  logic                       q_full,
    input  logic                       init_done,
    output logic                       q_push,
    output gadj_pkg::item_t            q_item
);

    logic [gadj_pkg::CNT_W-1:0] vcount_reg;
    logic [gadj_pkg::VTX_W-1:0] src;
    logic [gadj_pkg::VTX_W-1:0] dst;
    logic                       src_oor;
    logic                       dst_oor;
    logic                       known_cmd;
    gadj_pkg::cmd_t             op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= gadj_pkg::VCOUNT_RST;
        end
        else if (cfg_we)
        begin
            vcount_reg <= cfg_wdata;
        end
    end

    assign src = s_axis_tdata[5:0];
    assign dst = s_axis_tdata[11:6];
    assign op  = gadj_pkg::cmd_t'(s_axis_tuser);

    // The count in use is the register capped at the number of vertices built.
    assign src_oor = ({1'b0, src} >= vcount_reg) || (32'(src) >= MAX_VERTICES);
    assign dst_oor = ({1'b0, dst} >= vcount_reg) || (32'(dst) >= MAX_VERTICES);

    assign known_cmd = (op == gadj_pkg::CMD_ADD) || (op == gadj_pkg::CMD_READ) ||
                       (op == gadj_pkg::CMD_CLEAR);

    assign s_axis_tready = !q_full && init_done;
    assign q_push        = s_axis_tvalid && s_axis_tready && known_cmd;

    always_comb
    begin
        q_item.op  = op;
        q_item.src = src;
        q_item.dst = dst;
        unique case (op)
            gadj_pkg::CMD_ADD:  q_item.range_err = src_oor || dst_oor;
            gadj_pkg::CMD_READ: q_item.range_err = src_oor;
            default:            q_item.range_err = 1'b0;
        endcase
    end

endmodule

@@ src/gadj_fifo.sv @@
// Short command queue between the front end and the back end.
module gadj_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  gadj_pkg::item_t push_item,
    input  logic            pop,
    output gadj_pkg::item_t head_item,
    output logic            full,
    output logic            empty
);

    localparam int unsigned PTR_W = (gadj_pkg::QUEUE_DEPTH > 1) ?
                                    $clog2(gadj_pkg::QUEUE_DEPTH) : 1;
    localparam int unsigned CNTQ_W = $clog2(gadj_pkg::QUEUE_DEPTH + 1);

    gadj_pkg::item_t     entry_reg [gadj_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [CNTQ_W-1:0]   count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (32'(p) == gadj_pkg::QUEUE_DEPTH - 1)
        begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    assign full      = (32'(count_reg) == gadj_pkg::QUEUE_DEPTH);
    assign empty     = (count_reg == '0);
    assign head_item = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNTQ_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNTQ_W'(1);
            end
        end
    end

endmodule

@@ src/gadj_back.sv @@
// Back end: list storage, sorted insertion, sorted readout and clearing.
module gadj_back #(
    parameter int unsigned MAX_VERTICES = gadj_pkg::MAX_VERTICES_DEF,
    parameter int unsigned MAX_DEGREE   = gadj_pkg::MAX_DEGREE_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  gadj_pkg::item_t q_item,
    output logic            q_pop,
    output logic            init_done,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [7:0]      m_axis_tdata,
    output logic            m_axis_tlast
);

    localparam int unsigned VW = $clog2(MAX_VERTICES);
    localparam int unsigned LW = $clog2(MAX_DEGREE + 1);
    localparam int unsigned AW = $clog2(MAX_VERTICES * MAX_DEGREE);
    localparam int unsigned DEPTH = MAX_VERTICES * MAX_DEGREE;

    gadj_pkg::back_state_t state_reg, state_next;
    gadj_pkg::item_t       item_reg, item_next;
    logic [LW-1:0]         len_a_reg, len_a_next;
    logic [LW-1:0]         len_b_reg, len_b_next;
    logic [VW-1:0]         ins_v_reg, ins_v_next;
    logic [5:0]            ins_val_reg, ins_val_next;
    logic [LW-1:0]         ins_len_reg, ins_len_next;
    logic [LW-1:0]         pos_reg, pos_next;
    logic                  phase_reg, phase_next;
    gadj_pkg::status_t     status_reg, status_next;
    logic [VW-1:0]         clr_idx_reg, clr_idx_next;
    logic                  out_valid_reg, out_valid_next;
    gadj_pkg::status_t     out_status_reg, out_status_next;
    logic [5:0]            out_nb_reg, out_nb_next;
    logic                  out_last_reg, out_last_next;

    logic [LW-1:0] len_mem [MAX_VERTICES];
    logic [LW-1:0] len_rd_reg;
    logic [VW-1:0] len_raddr;
    logic          len_we;
    logic [VW-1:0] len_waddr;
    logic [LW-1:0] len_wdata;

    logic [5:0]    nb_mem [DEPTH];
    logic [5:0]    nb_rd_reg;
    logic [AW-1:0] nb_raddr;
    logic          nb_we;
    logic [AW-1:0] nb_waddr;
    logic [5:0]    nb_wdata;

    logic          out_free;
    logic          add_full;
    logic          shift_up;
    logic          ins_finish;
    logic          clr_last;
    logic          rd_last;
    logic [LW-1:0] second_len;

    function automatic logic [AW-1:0] slot(input logic [VW-1:0] v, input logic [LW-1:0] p);
        return AW'(v) * AW'(MAX_DEGREE) + AW'(p);
    endfunction

    // Storage with registered read ports.
    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[len_waddr] <= len_wdata;
        end
        len_rd_reg <= len_mem[len_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (nb_we)
        begin
            nb_mem[nb_waddr] <= nb_wdata;
        end
        nb_rd_reg <= nb_mem[nb_raddr];
    end

    assign out_free = !out_valid_reg || m_axis_tready;
    assign add_full = (item_reg.src == item_reg.dst) ?
                      (32'(len_a_reg) + 2 > MAX_DEGREE) :
                      ((32'(len_a_reg) >= MAX_DEGREE) || (32'(len_rd_reg) >= MAX_DEGREE));
    assign shift_up   = (state_reg == gadj_pkg::S_INS_CMP) && (nb_rd_reg > ins_val_reg);
    assign ins_finish = ((state_reg == gadj_pkg::S_INS_STEP) && (pos_reg == '0)) ||
                        ((state_reg == gadj_pkg::S_INS_CMP) && !shift_up);
    assign clr_last   = (32'(clr_idx_reg) == MAX_VERTICES - 1);
    assign rd_last    = (pos_reg + LW'(1) == len_a_reg);
    // A self-loop lands its second entry in the list that just grew.
    assign second_len = (item_reg.src == item_reg.dst) ? ins_len_reg + LW'(1) : len_b_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gadj_pkg::S_INIT:
            begin
                if (clr_last)
                begin
                    state_next = gadj_pkg::S_IDLE;
                end
            end
            gadj_pkg::S_IDLE:
            begin
                if (!q_empty)
                begin
                    priority if (q_item.range_err)
                        state_next = gadj_pkg::S_RESP;
                    else if (q_item.op == gadj_pkg::CMD_ADD)
                        state_next = gadj_pkg::S_LEN_SRC;
                    else if (q_item.op == gadj_pkg::CMD_READ)
                        state_next = gadj_pkg::S_RD_LEN;
                    else
                        state_next = gadj_pkg::S_CLR;
                end
            end
            gadj_pkg::S_LEN_SRC: state_next = gadj_pkg::S_LEN_DST;
            gadj_pkg::S_LEN_DST:
            begin
                state_next = add_full ? gadj_pkg::S_RESP : gadj_pkg::S_INS_STEP;
            end
            gadj_pkg::S_INS_STEP:
            begin
                if (ins_finish)
                begin
                    state_next = phase_reg ? gadj_pkg::S_RESP : gadj_pkg::S_INS_STEP;
                end
                else
                begin
                    state_next = gadj_pkg::S_INS_CMP;
                end
            end
            gadj_pkg::S_INS_CMP:
            begin
                if (ins_finish && phase_reg)
                begin
                    state_next = gadj_pkg::S_RESP;
                end
                else
                begin
                    state_next = gadj_pkg::S_INS_STEP;
                end
            end
            gadj_pkg::S_RD_LEN:
            begin
                state_next = (len_rd_reg == '0) ? gadj_pkg::S_RESP : gadj_pkg::S_RD_ADDR;
            end
            gadj_pkg::S_RD_ADDR:
            begin
                if (out_free)
                begin
                    state_next = gadj_pkg::S_RD_DATA;
                end
            end
            gadj_pkg::S_RD_DATA:
            begin
                state_next = rd_last ? gadj_pkg::S_IDLE : gadj_pkg::S_RD_ADDR;
            end
            gadj_pkg::S_CLR:
            begin
                if (clr_last)
                begin
                    state_next = gadj_pkg::S_RESP;
                end
            end
            gadj_pkg::S_RESP:
            begin
                if (out_free)
                begin
                    state_next = gadj_pkg::S_IDLE;
                end
            end
            default: state_next = gadj_pkg::S_IDLE;
        endcase
    end

    // Datapath, memory controls and output register loads.
    always_comb
    begin
        item_next       = item_reg;
        len_a_next      = len_a_reg;
        len_b_next      = len_b_reg;
        ins_v_next      = ins_v_reg;
        ins_val_next    = ins_val_reg;
        ins_len_next    = ins_len_reg;
        pos_next        = pos_reg;
        phase_next      = phase_reg;
        status_next     = status_reg;
        clr_idx_next    = clr_idx_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_nb_next     = out_nb_reg;
        out_last_next   = out_last_reg;
        q_pop           = 1'b0;
        len_raddr       = VW'(item_reg.src);
        len_we          = 1'b0;
        len_waddr       = clr_idx_reg;
        len_wdata       = '0;
        nb_raddr        = slot(ins_v_reg, pos_reg);
        nb_we           = 1'b0;
        nb_waddr        = slot(ins_v_reg, pos_reg);
        nb_wdata        = ins_val_reg;

        unique case (state_reg)
            gadj_pkg::S_INIT:
            begin
                len_we       = 1'b1;
                clr_idx_next = clr_idx_reg + VW'(1);
            end
            gadj_pkg::S_IDLE:
            begin
                len_raddr = VW'(q_item.src);
                if (!q_empty)
                begin
                    q_pop        = 1'b1;
                    item_next    = q_item;
                    clr_idx_next = '0;
                    status_next  = q_item.range_err ? gadj_pkg::ST_RANGE : gadj_pkg::ST_OK;
                end
            end
            gadj_pkg::S_LEN_SRC:
            begin
                len_raddr  = VW'(item_reg.dst);
                len_a_next = len_rd_reg;
            end
            gadj_pkg::S_LEN_DST:
            begin
                len_b_next = len_rd_reg;
                if (add_full)
                begin
                    status_next = gadj_pkg::ST_FULL;
                end
                else
                begin
                    phase_next   = 1'b0;
                    ins_v_next   = VW'(item_reg.src);
                    ins_val_next = item_reg.dst;
                    ins_len_next = len_a_reg;
                    pos_next     = len_a_reg;
                end
            end
            gadj_pkg::S_INS_STEP:
            begin
                nb_raddr = slot(ins_v_reg, pos_reg - LW'(1));
            end
            gadj_pkg::S_INS_CMP:
            begin
                if (shift_up)
                begin
                    nb_we    = 1'b1;
                    nb_wdata = nb_rd_reg;
                    pos_next = pos_reg - LW'(1);
                end
            end
            gadj_pkg::S_RD_LEN:
            begin
                len_a_next = len_rd_reg;
                pos_next   = '0;
                if (len_rd_reg == '0)
                begin
                    status_next = gadj_pkg::ST_EMPTY;
                end
            end
            gadj_pkg::S_RD_ADDR:
            begin
                nb_raddr = slot(VW'(item_reg.src), pos_reg);
            end
            gadj_pkg::S_RD_DATA:
            begin
                // The slot was free when the read was issued, so it is empty now.
                out_valid_next  = 1'b1;
                out_status_next = gadj_pkg::ST_OK;
                out_nb_next     = nb_rd_reg;
                out_last_next   = rd_last;
                pos_next        = pos_reg + LW'(1);
            end
            gadj_pkg::S_CLR:
            begin
                len_we       = 1'b1;
                clr_idx_next = clr_idx_reg + VW'(1);
                status_next  = gadj_pkg::ST_OK;
            end
            gadj_pkg::S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_nb_next     = '0;
                    out_last_next   = 1'b1;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase

        // Closing an insertion: place the value, bump the length, then move on.
        if (ins_finish)
        begin
            nb_we     = 1'b1;
            nb_wdata  = ins_val_reg;
            len_we    = 1'b1;
            len_waddr = ins_v_reg;
            len_wdata = ins_len_reg + LW'(1);
            if (!phase_reg)
            begin
                phase_next   = 1'b1;
                ins_v_next   = VW'(item_reg.dst);
                ins_val_next = item_reg.src;
                ins_len_next = second_len;
                pos_next     = second_len;
            end
            else
            begin
                status_next = gadj_pkg::ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gadj_pkg::S_INIT;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        len_a_reg      <= len_a_next;
        len_b_reg      <= len_b_next;
        ins_v_reg      <= ins_v_next;
        ins_val_reg    <= ins_val_next;
        ins_len_reg    <= ins_len_next;
        pos_reg        <= pos_next;
        phase_reg      <= phase_next;
        status_reg     <= status_next;
        out_status_reg <= out_status_next;
        out_nb_reg     <= out_nb_next;
        out_last_reg   <= out_last_next;
    end

    assign init_done     = (state_reg != gadj_pkg::S_INIT);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_nb_reg, out_status_reg};
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTH
    a_rd_slot_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == gadj_pkg::S_RD_DATA |-> !out_valid_reg)
        else $error("readout data arrived with output register occupied");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_we |-> 32'(len_wdata) <= MAX_DEGREE)
        else $error("list length written above maximum degree");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == gadj_pkg::S_IDLE) && !q_empty)
        else $error("command taken outside idle or from empty queue");
`endif

endmodule
